// ===== src/cdp_pkg.sv =====
// ----------------------------------------------------------------------------
// Checked decimal parser package
// Phase encoding, character constants and the overflow limit shared by the
// parser modules.
// ----------------------------------------------------------------------------
package cdp_pkg;

  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_SIGNED = 3'd1,
    PH_DIGITS = 3'd2,
    PH_TRAIL  = 3'd3,
    PH_DONE   = 3'd4,
    PH_ERR    = 3'd5
  } phase_t;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [63:0] TENTH_LIMIT = 64'd922337203685477580;
  localparam logic [3:0]  LAST_POS    = 4'd7;
  localparam logic [3:0]  LAST_NEG    = 4'd8;

endpackage

// ===== src/cdp_if.sv =====
// ----------------------------------------------------------------------------
// Checked decimal parser channels
// Valid/ready channels for text bytes in and parsed results out.
// ----------------------------------------------------------------------------
interface cdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_marker;

  modport source (output valid, char_code, end_marker, input ready);
  modport sink (input valid, char_code, end_marker, output ready);
endinterface

interface cdp_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic               ok;

  modport source (output valid, value, ok, input ready);
  modport sink (input valid, value, ok, output ready);
endinterface

// ===== src/cdp_digit_acc.sv =====
// ----------------------------------------------------------------------------
// Checked decimal parser digit accumulator
// Computes magnitude * 10 + digit and flags a digit that would leave the
// signed 64-bit range.
// ----------------------------------------------------------------------------
module cdp_digit_acc
  import cdp_pkg::*;
(
  input  logic [63:0] magnitude,
  input  logic        negative,
  input  logic [3:0]  digit,
  output logic [63:0] sum,
  output logic        overflow
);

  logic [3:0] last_digit;

  assign last_digit = negative ? LAST_NEG : LAST_POS;
  assign sum = {magnitude[60:0], 3'b000} + {magnitude[62:0], 1'b0} + {60'd0, digit};
  assign overflow = (magnitude > TENTH_LIMIT) ||
                    ((magnitude == TENTH_LIMIT) && (digit > last_digit));

endmodule

// ===== src/checked_decimal_to_int64_parser.sv =====
// ----------------------------------------------------------------------------
// Checked decimal to int64 parser
// Parses a decimal text, one byte per transaction, into a signed 64-bit value.
// ----------------------------------------------------------------------------
// Each byte is registered, then a single pass of logic updates the parse
// phase, the sign and the magnitude, where the multiply by ten is two shifts
// and an add. An end marker transaction is registered and, once it advances,
// loads the result register. The block takes one text byte per cycle and can
// accept a transaction in every cycle; while a result waits on the output, it
// keeps taking ordinary bytes and stalls only a second end marker. Leading
// white space and one sign are skipped, at least one digit is required, only
// spaces or tabs may trail, a zero byte after digits ends the text early,
// and any overflow or bad byte gives ok low with a zero value.
module checked_decimal_to_int64_parser
  import cdp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  cdp_in_if.sink    in_ch,
  cdp_out_if.source out_ch
);

  logic        s1_valid;
  logic [7:0]  s1_char;
  logic        s1_end;
  logic        adv;

  phase_t      phase;
  phase_t      phase_next;
  logic        is_negative;
  logic        is_negative_next;
  logic [63:0] magnitude;
  logic [63:0] magnitude_next;

  logic        out_valid;
  logic [63:0] out_value;
  logic        out_ok;

  logic        c_nul;
  logic        c_digit;
  logic        c_blank;
  logic        c_lead;
  logic [7:0]  c_off;
  logic [63:0] acc_sum;
  logic        acc_ovf;
  logic        take_digit;
  logic        end_ok;

  assign adv = s1_valid && (!s1_end || !out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      s1_char <= in_ch.char_code;
      s1_end  <= in_ch.end_marker;
    end
  end

  assign c_nul   = (s1_char == CHAR_NUL);
  assign c_digit = (s1_char >= CHAR_ZERO) && (s1_char <= CHAR_NINE);
  assign c_blank = (s1_char == CHAR_SPACE) || (s1_char == CHAR_TAB);
  assign c_lead  = (s1_char == CHAR_SPACE) || ((s1_char >= CHAR_TAB) && (s1_char <= CHAR_CR));
  assign c_off   = s1_char - CHAR_ZERO;

  cdp_digit_acc u_acc (
    .magnitude (magnitude),
    .negative  (is_negative),
    .digit     (c_off[3:0]),
    .sum       (acc_sum),
    .overflow  (acc_ovf)
  );

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_LEAD: begin
        if (c_nul) begin
          phase_next = PH_ERR;
        end else if (c_lead) begin
          phase_next = PH_LEAD;
        end else if ((s1_char == CHAR_MINUS) || (s1_char == CHAR_PLUS)) begin
          phase_next = PH_SIGNED;
        end else if (c_digit) begin
          phase_next = acc_ovf ? PH_ERR : PH_DIGITS;
        end else begin
          phase_next = PH_ERR;
        end
      end
      PH_SIGNED: begin
        if (c_digit) begin
          phase_next = acc_ovf ? PH_ERR : PH_DIGITS;
        end else begin
          phase_next = PH_ERR;
        end
      end
      PH_DIGITS: begin
        if (c_nul) begin
          phase_next = PH_DONE;
        end else if (c_digit) begin
          phase_next = acc_ovf ? PH_ERR : PH_DIGITS;
        end else if (c_blank) begin
          phase_next = PH_TRAIL;
        end else begin
          phase_next = PH_ERR;
        end
      end
      PH_TRAIL: begin
        if (c_nul) begin
          phase_next = PH_DONE;
        end else if (!c_blank) begin
          phase_next = PH_ERR;
        end
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_ERR;
      end
    endcase
  end

  assign take_digit = c_digit && !acc_ovf &&
                      ((phase == PH_LEAD) || (phase == PH_SIGNED) || (phase == PH_DIGITS));

  always_comb begin
    is_negative_next = is_negative;
    magnitude_next   = magnitude;
    if ((phase == PH_LEAD) && (s1_char == CHAR_MINUS)) begin
      is_negative_next = 1'b1;
    end
    if (take_digit) begin
      magnitude_next = acc_sum;
    end
  end

  assign end_ok = (phase == PH_DIGITS) || (phase == PH_TRAIL) || (phase == PH_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LEAD;
      is_negative <= 1'b0;
      magnitude   <= 64'd0;
    end else if (adv) begin
      if (s1_end) begin
        phase       <= PH_LEAD;
        is_negative <= 1'b0;
        magnitude   <= 64'd0;
      end else begin
        phase       <= phase_next;
        is_negative <= is_negative_next;
        magnitude   <= magnitude_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && s1_end) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
    if (adv && s1_end) begin
      out_ok <= end_ok;
      if (!end_ok) begin
        out_value <= 64'd0;
      end else if (is_negative) begin
        out_value <= 64'd0 - magnitude;
      end else begin
        out_value <= magnitude;
      end
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.value = out_value;
  assign out_ch.ok    = out_ok;

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// Checked decimal to int64 parser testbench
// Sends decimal texts one byte per transaction, with random gaps on the input
// and random stalls on the output. A parse tracker in the bench predicts each
// signed value and ok flag, and every result is checked against the oldest
// prediction. A short directed set of texts is followed by random texts. Most
// of these are well formed. The rest are corrupted or pure noise.
// ----------------------------------------------------------------------------
module tb;
  import cdp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TEXT_BYTES  = 900;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_marker;
  } text_byte_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic               ok;
  } parse_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cdp_in_if  in_ch();
  cdp_out_if out_ch();

  checked_decimal_to_int64_parser DUT (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_byte_t    pending_bytes[$];
  parse_result_t expected_results[$];
  int            bytes_queued   = 0;
  int            bytes_sent     = 0;
  int            mismatch_count = 0;
  int            cycle_count    = 0;

  phase_t      parse_phase = PH_LEAD;
  logic        parse_neg   = 1'b0;
  logic [63:0] parse_mag   = '0;

  function automatic bit lead_space(logic [7:0] c);
    return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  function automatic bit blank(logic [7:0] c);
    return c == CHAR_SPACE || c == CHAR_TAB;
  endfunction

  function automatic bit digit(logic [7:0] c);
    return c >= CHAR_ZERO && c <= CHAR_NINE;
  endfunction

  // The magnitude is checked before it is scaled, so it can never wrap.
  task automatic accumulate_digit(input logic [7:0] c);
    logic [63:0] d;
    logic [63:0] last;
    d = {56'd0, 8'(c - CHAR_ZERO)};
    last = parse_neg ? {60'd0, LAST_NEG} : {60'd0, LAST_POS};
    if (parse_mag > TENTH_LIMIT || (parse_mag == TENTH_LIMIT && d > last)) begin
      parse_phase = PH_ERR;
    end else begin
      parse_mag = parse_mag * 64'd10 + d;
      parse_phase = PH_DIGITS;
    end
  endtask

  task automatic track_byte(input logic [7:0] c, input logic end_mark);
    parse_result_t res;
    if (end_mark) begin
      res.ok = parse_phase == PH_DIGITS || parse_phase == PH_TRAIL || parse_phase == PH_DONE;
      res.value = !res.ok ? 64'd0 : (parse_neg ? 64'd0 - parse_mag : parse_mag);
      expected_results.push_back(res);
      parse_phase = PH_LEAD;
      parse_neg = 1'b0;
      parse_mag = '0;
    end else begin
      case (parse_phase)
        PH_LEAD: begin
          if (c == CHAR_NUL) parse_phase = PH_ERR;
          else if (lead_space(c)) parse_phase = PH_LEAD;
          else if (c == CHAR_MINUS) begin
            parse_neg = 1'b1;
            parse_phase = PH_SIGNED;
          end else if (c == CHAR_PLUS) parse_phase = PH_SIGNED;
          else if (digit(c)) accumulate_digit(c);
          else parse_phase = PH_ERR;
        end
        PH_SIGNED: begin
          if (digit(c)) accumulate_digit(c);
          else parse_phase = PH_ERR;
        end
        PH_DIGITS: begin
          if (c == CHAR_NUL) parse_phase = PH_DONE;
          else if (digit(c)) accumulate_digit(c);
          else if (blank(c)) parse_phase = PH_TRAIL;
          else parse_phase = PH_ERR;
        end
        PH_TRAIL: begin
          if (c == CHAR_NUL) parse_phase = PH_DONE;
          else if (!blank(c)) parse_phase = PH_ERR;
        end
        PH_DONE: begin
        end
        default: begin
          parse_phase = PH_ERR;
        end
      endcase
    end
  endtask

  function automatic int idle_draw(bit burst);
    return burst ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic logic [7:0] rand_digit();
    return CHAR_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 7))
      0: return CHAR_SPACE;
      1: return CHAR_TAB;
      2: return CHAR_PLUS;
      3: return CHAR_MINUS;
      4: return rand_digit();
      5: return CHAR_NUL;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] c);
    pending_bytes.push_back('{char_code: c, end_marker: 1'b0});
    bytes_queued++;
  endtask

  task automatic push_end();
    pending_bytes.push_back('{char_code: 8'($urandom_range(0, 255)), end_marker: 1'b1});
    bytes_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic queue_random_text();
    int form;
    bit corrupt;
    bit corrupt_early;
    form = $urandom_range(0, 9);
    corrupt = form == 9;
    corrupt_early = $urandom_range(0, 1);
    if (form == 7 || form == 8) begin
      repeat ($urandom_range(0, 6)) push_byte(noise_byte());
    end else begin
      repeat ($urandom_range(0, 3)) begin
        if ($urandom_range(0, 5) == 0) push_byte(CHAR_SPACE);
        else push_byte(CHAR_TAB + 8'($urandom_range(0, 4)));
      end
      case ($urandom_range(0, 2))
        1: push_byte(CHAR_PLUS);
        2: push_byte(CHAR_MINUS);
        default: begin
        end
      endcase
      if (corrupt && corrupt_early) push_byte(noise_byte());
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) push_byte(CHAR_ZERO);
      case ($urandom_range(0, 3))
        0: repeat ($urandom_range(1, 3)) push_byte(rand_digit());
        1: repeat ($urandom_range(1, 19)) push_byte(rand_digit());
        2: begin
          push_text("922337203685477580");
          push_byte(rand_digit());
          if ($urandom_range(0, 3) == 0) push_byte(rand_digit());
        end
        default: repeat ($urandom_range(19, 21)) push_byte(rand_digit());
      endcase
      if (corrupt && !corrupt_early) push_byte(noise_byte());
      repeat ($urandom_range(0, 2)) push_byte($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
      if ($urandom_range(0, 3) == 0) begin
        push_byte(CHAR_NUL);
        repeat ($urandom_range(0, 2)) push_byte(noise_byte());
      end
    end
    push_end();
  endtask

  text_byte_t    cur_byte;
  int            in_gap    = 0;
  bit            in_burst  = 1'b0;
  parse_result_t want;
  int            out_gap   = 0;
  bit            out_burst = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.char_code <= '0;
      in_ch.end_marker <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        track_byte(in_ch.char_code, in_ch.end_marker);
        bytes_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          cur_byte = pending_bytes.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.char_code <= cur_byte.char_code;
          in_ch.end_marker <= cur_byte.end_marker;
          if ($urandom_range(0, 47) == 0) in_burst = !in_burst;
          in_gap = idle_draw(in_burst);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: unexpected result value=%0d ok=%0b", out_ch.value, out_ch.ok);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.value !== want.value || out_ch.ok !== want.ok) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected value=%0d ok=%0b, actual value=%0d ok=%0b",
                       want.value, want.ok, out_ch.value, out_ch.ok);
          end
        end
        if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
        out_gap = idle_draw(out_burst);
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    push_text("\n-0\t");
    push_end();
    push_text("+9");
    push_byte(CHAR_NUL);
    push_text("x");
    push_end();
    push_text("-");
    push_end();
    push_end();
    push_text(" 1 2");
    push_end();
    push_byte(8'hFF);
    push_end();
    push_byte(CHAR_NUL);
    push_end();
    while (bytes_queued < TEXT_BYTES) queue_random_text();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (bytes_sent < bytes_queued || expected_results.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== checked_decimal_to_int64_parser.f =====
src/cdp_pkg.sv
src/cdp_if.sv
src/cdp_digit_acc.sv
src/checked_decimal_to_int64_parser.sv
dv/tb.sv
